// ===== sv/ndf_pkg.sv =====
`timescale 1ns / 1ps

package ndf_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [15:0] region_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_CLOSED   = 2'd1,
    ST_OPEN     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_PATTERN  = 3'd0,
    REG_OPEN_LENGTH   = 3'd1,
    REG_CLOSE_PATTERN = 3'd2,
    REG_CLOSE_LENGTH  = 3'd3,
    REG_ESCAPE_ENABLE = 3'd4,
    REG_ESCAPE_BYTE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] open_pattern;
    logic [2:0]  open_length;
    logic [31:0] close_pattern;
    logic [2:0]  close_length;
    logic        escape_enable;
    logic [7:0]  escape_byte;
  } cfg_t;

  localparam logic [31:0] RST_OPEN_PATTERN  = 32'd123;
  localparam logic [2:0]  RST_OPEN_LENGTH   = 3'd1;
  localparam logic [31:0] RST_CLOSE_PATTERN = 32'd125;
  localparam logic [2:0]  RST_CLOSE_LENGTH  = 3'd1;
  localparam logic        RST_ESCAPE_ENABLE = 1'b0;
  localparam logic [7:0]  RST_ESCAPE_BYTE   = 8'd92;

endpackage

// ===== sv/ndf_cfg.sv =====
`timescale 1ns / 1ps

module ndf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ndf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ndf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output ndf_pkg::cfg_t                       cfg_o
);

  ndf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_pattern  <= ndf_pkg::RST_OPEN_PATTERN;
      cfg_q.open_length   <= ndf_pkg::RST_OPEN_LENGTH;
      cfg_q.close_pattern <= ndf_pkg::RST_CLOSE_PATTERN;
      cfg_q.close_length  <= ndf_pkg::RST_CLOSE_LENGTH;
      cfg_q.escape_enable <= ndf_pkg::RST_ESCAPE_ENABLE;
      cfg_q.escape_byte   <= ndf_pkg::RST_ESCAPE_BYTE;
    end else if (cfg_we_i) begin
      case (ndf_pkg::cfg_idx_e'(cfg_index_i))
        ndf_pkg::REG_OPEN_PATTERN:  cfg_q.open_pattern  <= cfg_data_i[31:0];
        ndf_pkg::REG_OPEN_LENGTH:   cfg_q.open_length   <= cfg_data_i[2:0];
        ndf_pkg::REG_CLOSE_PATTERN: cfg_q.close_pattern <= cfg_data_i[31:0];
        ndf_pkg::REG_CLOSE_LENGTH:  cfg_q.close_length  <= cfg_data_i[2:0];
        ndf_pkg::REG_ESCAPE_ENABLE: cfg_q.escape_enable <= cfg_data_i[0];
        ndf_pkg::REG_ESCAPE_BYTE:   cfg_q.escape_byte   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ndf_front.sv =====
`timescale 1ns / 1ps

module ndf_front #(
  parameter int unsigned MAX_DELIM = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ndf_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_in_i,
  input  logic                 end_of_text_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic                 q_last_o,
  output logic                 q_esc_o,
  output logic [MAX_DELIM-1:0] q_oeq_o,
  output logic [MAX_DELIM-1:0] q_ceq_o
);

  localparam int unsigned QD  = 4;
  localparam int unsigned QPW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  logic                 last_q [QD];
  logic                 esc_q  [QD];
  logic [MAX_DELIM-1:0] oeq_q  [QD];
  logic [MAX_DELIM-1:0] ceq_q  [QD];

  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;

  logic                 push;
  logic                 pop;
  logic                 in_esc;
  logic [MAX_DELIM-1:0] in_oeq;
  logic [MAX_DELIM-1:0] in_ceq;

  assign in_stall_o = (count_q == QCW'(QD));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  // classify each byte against every delimiter slot and the escape byte
  always_comb begin
    in_esc = cfg_i.escape_enable && (char_in_i == cfg_i.escape_byte);
    for (int k = 0; k < MAX_DELIM; k++) begin
      in_oeq[k] = (char_in_i == 8'(cfg_i.open_pattern >> (8 * k)));
      in_ceq[k] = (char_in_i == 8'(cfg_i.close_pattern >> (8 * k)));
    end
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      last_q[wr_ptr_q] <= end_of_text_i;
      esc_q[wr_ptr_q]  <= in_esc;
      oeq_q[wr_ptr_q]  <= in_oeq;
      ceq_q[wr_ptr_q]  <= in_ceq;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_last_o  = last_q[rd_ptr_q];
  assign q_esc_o   = esc_q[rd_ptr_q];
  assign q_oeq_o   = oeq_q[rd_ptr_q];
  assign q_ceq_o   = ceq_q[rd_ptr_q];

endmodule

// ===== sv/ndf_back.sv =====
`timescale 1ns / 1ps

module ndf_back #(
  parameter int unsigned MAX_DELIM   = 4,
  parameter int unsigned POS_WIDTH   = 16,
  parameter int unsigned DEPTH_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ndf_pkg::cfg_t        cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  logic                 q_last_i,
  input  logic                 q_esc_i,
  input  logic [MAX_DELIM-1:0] q_oeq_i,
  input  logic [MAX_DELIM-1:0] q_ceq_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output ndf_pkg::region_t     region_start_o,
  output ndf_pkg::region_t     region_length_o
);

  localparam int unsigned LW  = $clog2(MAX_DELIM + 1);
  localparam int unsigned IW  = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int unsigned PW1 = POS_WIDTH + 1;

  // window: per held position, escape flag and per-slot compare bits
  logic [MAX_DELIM-1:0]                wesc_q, wesc_d, w_esc;
  logic [MAX_DELIM-1:0][MAX_DELIM-1:0] woeq_q, woeq_d, w_oeq;
  logic [MAX_DELIM-1:0][MAX_DELIM-1:0] wceq_q, wceq_d, w_ceq;

  logic [LW-1:0]          fill_q, fill_d, f;
  logic                   drain_q, drain_d;
  logic [PW1-1:0]         pos_q, pos_d;
  logic                   opened_q, opened_d;
  logic [POS_WIDTH-1:0]   open_pos_q, open_pos_d;
  logic [DEPTH_WIDTH-1:0] depth_q, depth_d;
  logic                   esc_pend_q, esc_pend_d;
  logic                   ans_q, ans_d;

  logic                   out_valid_q;
  ndf_pkg::status_e       status_q;
  ndf_pkg::region_t       start_q;
  ndf_pkg::region_t       len_q;

  logic                   out_free;
  logic                   back_go;
  logic                   do_test;
  logic [LW-1:0]          eff_o, eff_c;
  logic                   match_open, match_close;
  logic [PW1-1:0]         close_len;

  logic                   res_vld;
  ndf_pkg::status_e       res_status;
  logic [POS_WIDTH-1:0]   res_start;
  logic [POS_WIDTH-1:0]   res_len;

  assign out_free = !out_valid_q || !out_stall_i;
  assign back_go  = out_free && (drain_q || q_valid_i);
  assign q_pop_o  = out_free && !drain_q && q_valid_i;

  always_comb begin
    if (cfg_i.open_length == '0) begin
      eff_o = LW'(1);
    end else if (int'(cfg_i.open_length) > MAX_DELIM) begin
      eff_o = LW'(MAX_DELIM);
    end else begin
      eff_o = LW'(cfg_i.open_length);
    end
    if (cfg_i.close_length == '0) begin
      eff_c = LW'(1);
    end else if (int'(cfg_i.close_length) > MAX_DELIM) begin
      eff_c = LW'(MAX_DELIM);
    end else begin
      eff_c = LW'(cfg_i.close_length);
    end
  end

  // window seen by this cycle's test: append the queue head unless draining
  always_comb begin
    w_esc = wesc_q;
    w_oeq = woeq_q;
    w_ceq = wceq_q;
    f     = fill_q;
    if (!drain_q) begin
      w_esc[fill_q[IW-1:0]] = q_esc_i;
      w_oeq[fill_q[IW-1:0]] = q_oeq_i;
      w_ceq[fill_q[IW-1:0]] = q_ceq_i;
      f = fill_q + 1'b1;
    end
  end

  assign do_test = drain_q || (f == LW'(MAX_DELIM));

  always_comb begin
    match_open  = (eff_o <= f);
    match_close = (eff_c <= f);
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (k < int'(eff_o) && !w_oeq[k][k]) match_open = 1'b0;
      if (k < int'(eff_c) && !w_ceq[k][k]) match_close = 1'b0;
    end
  end

  assign close_len = {1'b0, pos_q[POS_WIDTH-1:0]} + PW1'(eff_c) - {1'b0, open_pos_q};

  always_comb begin
    wesc_d     = wesc_q;
    woeq_d     = woeq_q;
    wceq_d     = wceq_q;
    fill_d     = fill_q;
    drain_d    = drain_q;
    pos_d      = pos_q;
    opened_d   = opened_q;
    open_pos_d = open_pos_q;
    depth_d    = depth_q;
    esc_pend_d = esc_pend_q;
    ans_d      = ans_q;
    res_vld    = 1'b0;
    res_status = ndf_pkg::ST_NONE;
    res_start  = '0;
    res_len    = '0;
    if (back_go) begin
      wesc_d = w_esc;
      woeq_d = w_oeq;
      wceq_d = w_ceq;
      fill_d = f;
      if (do_test) begin
        if (!ans_q) begin
          if (pos_q[POS_WIDTH]) begin
            res_vld    = 1'b1;
            res_status = ndf_pkg::ST_OVERFLOW;
            ans_d      = 1'b1;
          end else if (w_esc[0] && !esc_pend_q) begin
            esc_pend_d = 1'b1;
          end else if (!esc_pend_q && match_open) begin
            esc_pend_d = 1'b0;
            if (!opened_q) begin
              opened_d   = 1'b1;
              open_pos_d = pos_q[POS_WIDTH-1:0];
            end else if (&depth_q) begin
              res_vld    = 1'b1;
              res_status = ndf_pkg::ST_OVERFLOW;
              ans_d      = 1'b1;
            end else begin
              depth_d = depth_q + 1'b1;
            end
          end else if (!esc_pend_q && opened_q && match_close) begin
            esc_pend_d = 1'b0;
            if (depth_q == '0) begin
              res_vld = 1'b1;
              ans_d   = 1'b1;
              if (close_len[POS_WIDTH]) begin
                res_status = ndf_pkg::ST_OVERFLOW;
              end else begin
                res_status = ndf_pkg::ST_CLOSED;
                res_start  = open_pos_q;
                res_len    = close_len[POS_WIDTH-1:0];
              end
            end else begin
              depth_d = depth_q - 1'b1;
            end
          end else begin
            esc_pend_d = 1'b0;
          end
        end
        // drop the oldest position
        for (int k = 0; k < MAX_DELIM - 1; k++) begin
          wesc_d[k] = w_esc[k+1];
          woeq_d[k] = w_oeq[k+1];
          wceq_d[k] = w_ceq[k+1];
        end
        wesc_d[MAX_DELIM-1] = 1'b0;
        woeq_d[MAX_DELIM-1] = '0;
        wceq_d[MAX_DELIM-1] = '0;
        fill_d = f - 1'b1;
        if (!pos_q[POS_WIDTH]) pos_d = pos_q + 1'b1;
      end
      if (drain_q || q_last_i) begin
        if (fill_d == '0 || ans_d) begin
          if (!ans_d) begin
            res_vld = 1'b1;
            if (opened_d) begin
              res_status = ndf_pkg::ST_OPEN;
              res_start  = open_pos_d;
            end else begin
              res_status = ndf_pkg::ST_NONE;
            end
          end
          fill_d     = '0;
          drain_d    = 1'b0;
          pos_d      = '0;
          opened_d   = 1'b0;
          open_pos_d = '0;
          depth_d    = '0;
          esc_pend_d = 1'b0;
          ans_d      = 1'b0;
        end else begin
          drain_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drain_q     <= 1'b0;
      pos_q       <= '0;
      opened_q    <= 1'b0;
      open_pos_q  <= '0;
      depth_q     <= '0;
      esc_pend_q  <= 1'b0;
      ans_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      drain_q    <= drain_d;
      pos_q      <= pos_d;
      opened_q   <= opened_d;
      open_pos_q <= open_pos_d;
      depth_q    <= depth_d;
      esc_pend_q <= esc_pend_d;
      ans_q      <= ans_d;
      if (out_free) out_valid_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    wesc_q <= wesc_d;
    woeq_q <= woeq_d;
    wceq_q <= wceq_d;
    if (out_free && res_vld) begin
      status_q <= res_status;
      start_q  <= ndf_pkg::region_t'(res_start);
      len_q    <= ndf_pkg::region_t'(res_len);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign region_start_o  = start_q;
  assign region_length_o = len_q;

endmodule

// ===== sv/nested_delimiter_finder_top.sv =====
`timescale 1ns / 1ps

// Finds the first region in a byte string that opens with the start delimiter and closes
// with its matching end delimiter, counting nested openings and honoring an optional
// escape byte, and gives exactly one item per string: closed region (start and length
// through the end delimiter), open region, none found, or overflow. Bytes enter one per
// cycle, unless the queue is full and stalls the input, into a four-item queue where each
// is compared against every delimiter slot; a back end walks a window of MAX_DELIM
// positions and, once it is full, tests one position per cycle while bytes arrive.
// After the last byte the positions still held in the window are tested one per cycle;
// the next string waits in the queue meanwhile. Once a result has been decided before the
// last byte, the window is cleared at the last byte without testing the held positions.
// A result waiting in the output register holds the back end. Closed and overflow
// results appear as soon as decided; open and none-found results follow the last byte.
// Write the configuration registers only while no string is in flight.
module nested_delimiter_finder_top #(
  parameter int unsigned MAX_DELIM   = 4,
  parameter int unsigned POS_WIDTH   = 16,
  parameter int unsigned DEPTH_WIDTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ndf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ndf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_in_i,
  input  logic                           end_of_text_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [15:0]                    region_start_o,
  output logic [15:0]                    region_length_o
);

  ndf_pkg::cfg_t        cfg;
  logic                 q_valid;
  logic                 q_pop;
  logic                 q_last;
  logic                 q_esc;
  logic [MAX_DELIM-1:0] q_oeq;
  logic [MAX_DELIM-1:0] q_ceq;

  ndf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ndf_front #(
    .MAX_DELIM (MAX_DELIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_last_o      (q_last),
    .q_esc_o       (q_esc),
    .q_oeq_o       (q_oeq),
    .q_ceq_o       (q_ceq)
  );

  ndf_back #(
    .MAX_DELIM   (MAX_DELIM),
    .POS_WIDTH   (POS_WIDTH),
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_last_i        (q_last),
    .q_esc_i         (q_esc),
    .q_oeq_i         (q_oeq),
    .q_ceq_i         (q_ceq),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .region_start_o  (region_start_o),
    .region_length_o (region_length_o)
  );

endmodule

// ===== sv/ndf_chk.sv =====
`timescale 1ns / 1ps

module ndf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] region_start_o,
  input logic [15:0] region_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(region_start_o) && $stable(region_length_o))
    else $error("result item changed while stalled");

  a_no_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ndf_pkg::ST_NONE || status_o == ndf_pkg::ST_OVERFLOW)
      |-> region_start_o == '0 && region_length_o == '0)
    else $error("region fields set without a region");

  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ndf_pkg::ST_OPEN |-> region_length_o == '0)
    else $error("open region with nonzero length");

  a_closed_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ndf_pkg::ST_CLOSED |-> region_length_o != '0)
    else $error("closed region with zero length");

endmodule

bind nested_delimiter_finder_top ndf_chk u_ndf_chk (.*);
